// ----- hw/rtl/gaussian_noise_pair_generator_defines.svh -----
// Assertion macros for the gaussian noise pair generator
`ifndef GAUSSIAN_NOISE_PAIR_GENERATOR_DEFINES_SVH
`define GAUSSIAN_NOISE_PAIR_GENERATOR_DEFINES_SVH
`ifndef SYNTH
`define GNPG_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gnpg: same-cycle check failed");
`define GNPG_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gnpg: next-cycle check failed");
`else
`define GNPG_ASSERT_IMP(name, clk, rst, ante, cons)
`define GNPG_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/gnpg_pkg.sv -----
// Types, constants and helpers shared by the gaussian noise pair generator
package gnpg_pkg;

  localparam int FB            = 56;
  localparam int LCG_W         = 31;
  localparam int SD_W          = 16;
  localparam int SD_FRAC_BITS  = 8;
  localparam int SAMPLE_W      = 25;
  localparam int THETA_SH      = 29;
  localparam int LN_TERMS      = 26;
  localparam int TRIG_TERMS    = 32;
  localparam int FDIV_STEPS    = 56;
  localparam int SQRT_STEPS    = 32;
  localparam int MUL_PARTS     = 4;
  localparam int DIV_BITS      = 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);

  localparam logic [LCG_W-1:0] LCG_MUL = 31'd1103515245;
  localparam logic [LCG_W-1:0] LCG_INC = 31'd12345;

  localparam logic [63:0] LN2_Q      = 64'h00B17217F7D1CF79;
  localparam logic [63:0] HALF_PI_Q  = 64'h01921FB54442D184;
  localparam logic [63:0] ONE_Q      = 64'h0100000000000000;
  localparam logic [63:0] SQRT_TOP   = 64'h4000000000000000;
  localparam logic [63:0] SAT_POS    = (64'd1 << (SAMPLE_W - 1)) - 64'd1;
  localparam logic [63:0] SAT_NEG    = 64'd1 << (SAMPLE_W - 1);
  localparam logic [15:0] SD_RESET   = 16'd256;

  typedef enum logic {
    ACT_DRAW = 1'b0,
    ACT_LOAD = 1'b1
  } action_t;

  typedef enum logic {
    REG_STD_DEV_X = 1'b0,
    REG_STD_DEV_Y = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [LCG_W-1:0] s1;
    logic [LCG_W-1:0] s2;
  } uniform_pair_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_FIRST,
    F_SECOND
  } front_state_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_FDIV,
    B_ZSQ,
    B_LN_DIV,
    B_LN_MUL,
    B_LN_WHOLE,
    B_SQRT,
    B_THETA,
    B_TRIG_ACC,
    B_TRIG_MUL,
    B_TRIG_DIV,
    B_QUAD,
    B_X_AMP,
    B_X_SCALE,
    B_Y_AMP,
    B_Y_SCALE,
    B_DONE
  } back_state_t;

  function automatic logic [LCG_W-1:0] lcg_next(input logic [LCG_W-1:0] s);
    // 31-bit arithmetic wraps modulo 2^31
    return s * LCG_MUL + LCG_INC;
  endfunction

endpackage

// ----- hw/rtl/gnpg_if.sv -----
// Request and result channel interfaces
interface gnpg_req_if import gnpg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [LCG_W-1:0] seed_value;

  modport source (output valid, output action, output seed_value, input ready);
  modport sink   (input valid, input action, input seed_value, output ready);
endinterface

interface gnpg_rsp_if import gnpg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_x;
  logic signed [SAMPLE_W-1:0] sample_y;

  modport source (output valid, output sample_x, output sample_y, input ready);
  modport sink   (input valid, input sample_x, input sample_y, output ready);
endinterface

// ----- hw/rtl/gaussian_noise_pair_generator.sv -----
// Gaussian noise pair generator: Box-Muller over a 31-bit LCG, Q.OUT_FRAC_BITS samples.
// A draw beat returns one (sample_x, sample_y) pair; a seed load gives no result. The
// draw time is set by the back-end sequencer, whose series for ln and sin/cos run on one
// shared 64-bit multiplier (four 32x32 partial products) and an eight-bit-a-cycle
// divider. The front end steps the generator twice a draw and keeps up to two pairs
// queued, and the result register holds one finished pair, so requests are taken
// while the back end is busy.
`include "gaussian_noise_pair_generator_defines.svh"
module gaussian_noise_pair_generator import gnpg_pkg::*; #(
  parameter int OUT_FRAC_BITS = 12
) (
  input  logic            clk,
  input  logic            rst,
  gnpg_req_if.sink        req,
  gnpg_rsp_if.source      rsp,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [SD_W-1:0] cfg_data
);

  logic [SD_W-1:0] std_dev_x, std_dev_y;
  logic            q_push, q_ready, q_pop, q_valid;
  uniform_pair_t   push_pair, pop_pair;

  always_ff @(posedge clk) begin
    if (rst) begin
      std_dev_x <= SD_RESET;
      std_dev_y <= SD_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_STD_DEV_X) std_dev_x <= cfg_data;
      else                            std_dev_y <= cfg_data;
    end
  end

  gnpg_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_pair  (push_pair)
  );

  gnpg_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (push_pair),
    .ready (q_ready),
    .pop   (q_pop),
    .dout  (pop_pair),
    .valid (q_valid)
  );

  gnpg_back #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_pair  (pop_pair),
    .q_pop   (q_pop),
    .sd_x    (std_dev_x),
    .sd_y    (std_dev_y),
    .rsp     (rsp)
  );

  `GNPG_ASSERT_IMP(a_push_has_room, clk, rst, q_push, q_ready)
  `GNPG_ASSERT_NXT(a_no_push_after_beat, clk, rst, req.valid && req.ready, !q_push)
  `GNPG_ASSERT_IMP(a_pop_has_entry, clk, rst, q_pop, q_valid)

endmodule

// ----- hw/rtl/gnpg_front.sv -----
// Front end: takes request beats, runs the LCG and queues uniform pairs
module gnpg_front import gnpg_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  gnpg_req_if.sink      req,
  input  logic          q_ready,
  output logic          q_push,
  output uniform_pair_t q_pair
);

  front_state_t     state, state_next;
  logic [LCG_W-1:0] lcg_state, lcg_state_next;
  logic [LCG_W-1:0] s1, s1_next;
  logic [LCG_W-1:0] adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      lcg_state <= '0;
    end else begin
      state     <= state_next;
      lcg_state <= lcg_state_next;
    end
  end

  always_ff @(posedge clk) begin
    s1 <= s1_next;
  end

  always_comb begin
    adv            = lcg_next(lcg_state);
    state_next     = state;
    lcg_state_next = lcg_state;
    s1_next        = s1;
    q_push         = 1'b0;
    req.ready      = 1'b0;
    unique case (state)
      F_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (req.action == ACT_LOAD) begin
            lcg_state_next = req.seed_value;
          end else begin
            state_next = F_FIRST;
          end
        end
      end
      F_FIRST: begin
        lcg_state_next = adv;
        s1_next        = adv;
        state_next     = F_SECOND;
      end
      F_SECOND: begin
        if (q_ready) begin
          q_push         = 1'b1;
          lcg_state_next = adv;
          state_next     = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  assign q_pair.s1 = s1;
  assign q_pair.s2 = adv;

endmodule

// ----- hw/rtl/gnpg_fifo.sv -----
// Short queue of uniform pairs between front and back ends
module gnpg_fifo import gnpg_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  uniform_pair_t din,
  output logic          ready,
  input  logic          pop,
  output uniform_pair_t dout,
  output logic          valid
);

  uniform_pair_t          slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign ready = (count != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hw/rtl/gnpg_mul.sv -----
// 64x64 multiplier built from four 32x32 partial products taken in turn
module gnpg_mul import gnpg_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);

  logic [63:0]  ra, rb, pp;
  logic [2:0]   idx;
  logic         busy;
  logic [31:0]  a_half, b_half;
  logic [127:0] pp_shifted;

  assign a_half = idx[1] ? ra[63:32] : ra[31:0];
  assign b_half = idx[0] ? rb[63:32] : rb[31:0];

  // offset of the partial product captured in the previous cycle
  always_comb begin
    priority case (idx)
      3'd1:       pp_shifted = {64'b0, pp};
      3'd2, 3'd3: pp_shifted = {32'b0, pp, 32'b0};
      default:    pp_shifted = {pp, 64'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
        ra   <= a;
        rb   <= b;
        prod <= '0;
      end else if (busy) begin
        if (idx != 3'(MUL_PARTS)) begin
          pp <= 64'(a_half) * 64'(b_half);
        end
        if (idx != '0) begin
          prod <= prod + pp_shifted;
        end
        idx <= idx + 1'b1;
        if (idx == 3'(MUL_PARTS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/gnpg_back.sv -----
// Back end: sequencer for ln, sqrt and sin/cos series and output scaling
module gnpg_back import gnpg_pkg::*; #(
  parameter int OUT_FRAC_BITS = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  uniform_pair_t    q_pair,
  output logic             q_pop,
  input  logic [SD_W-1:0]  sd_x,
  input  logic [SD_W-1:0]  sd_y,
  gnpg_rsp_if.source       rsp
);

  localparam int ROUND_SH = FB + SD_FRAC_BITS - OUT_FRAC_BITS;

  back_state_t      state, state_next;
  logic [5:0]       step;
  logic [4:0]       e, e_in;
  logic [LCG_W-1:0] s2, s1_fix, p_in;
  logic [32:0]      fd_r, fd_d, fd_r2, fd_r_step;
  logic             fd_ge;
  logic [55:0]      fd_q, fd_q_step;
  logic [63:0]      t, w, sum, vrad, root, sq_bit, r, theta;
  logic [63:0]      sq_cand, root_step, whole, lnm, neg_ln;
  logic             sq_ge;
  logic signed [63:0] c, sn, cx, sy, term, cx_sel, sy_sel;
  logic [SAMPLE_W-1:0] px, py;
  logic               out_valid, out_load;
  logic signed [SAMPLE_W-1:0] out_x, out_y;

  logic         mul_start, mul_done;
  logic [63:0]  mul_a, mul_b, prod_mid, scaled;
  logic [127:0] mul_prod, rounded;

  logic         div_start, div_busy, div_fin;
  logic [63:0]  div_a, div_q, dv_q;
  logic [5:0]   div_d, div_dsor, div_rem, dv_r;
  logic [6:0]   dv_r7;
  logic [2:0]   div_cnt;

  function automatic logic [4:0] msb_index(input logic [LCG_W-1:0] s);
    logic [4:0] idx;
    idx = '0;
    for (int i = 0; i < LCG_W; i++) begin
      if (s[i]) idx = 5'(i);
    end
    return idx;
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    logic [63:0] m;
    m = v;
    if (v[63]) m = ~m + 64'd1;
    return m;
  endfunction

  function automatic logic [SAMPLE_W-1:0] saturate(input logic [63:0] p, input logic neg);
    logic [63:0] m;
    if (neg) begin
      m = (p > SAT_NEG) ? SAT_NEG : p;
      m = ~m + 64'd1;
    end else begin
      m = (p > SAT_POS) ? SAT_POS : p;
    end
    return m[SAMPLE_W-1:0];
  endfunction

  gnpg_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign prod_mid = mul_prod[FB +: 64];
  assign rounded  = mul_prod + (128'd1 << (ROUND_SH - 1));
  assign scaled   = rounded[ROUND_SH +: 64];

  // a zero uniform is taken as the smallest step
  assign s1_fix = (q_pair.s1 == '0) ? LCG_W'(1) : q_pair.s1;
  assign e_in   = msb_index(s1_fix);
  assign p_in   = LCG_W'(1) << e_in;

  assign fd_r2     = {fd_r[31:0], 1'b0};
  assign fd_ge     = (fd_r2 >= fd_d);
  assign fd_r_step = fd_ge ? fd_r2 - fd_d : fd_r2;
  assign fd_q_step = {fd_q[54:0], fd_ge};

  assign whole  = mul_prod[63:0];
  assign lnm    = {sum[62:0], 1'b0};
  assign neg_ln = (whole > lnm) ? whole - lnm : '0;

  assign sq_cand   = root + sq_bit;
  assign sq_ge     = (vrad >= sq_cand);
  assign root_step = sq_ge ? (root >> 1) + sq_bit : root >> 1;

  assign term = step[1] ? -$signed(t) : $signed(t);

  always_comb begin
    unique case (s2[LCG_W-1:LCG_W-2])
      2'd0:    begin cx_sel = c;   sy_sel = sn;  end
      2'd1:    begin cx_sel = -sn; sy_sel = c;   end
      2'd2:    begin cx_sel = -c;  sy_sel = -sn; end
      default: begin cx_sel = sn;  sy_sel = -c;  end
    endcase
  end

  // narrow divisor: eight restoring steps a cycle
  always_comb begin
    dv_r  = div_rem;
    dv_q  = div_q;
    dv_r7 = '0;
    for (int j = 0; j < DIV_BITS; j++) begin
      dv_r7 = {dv_r, dv_q[63]};
      dv_q  = {dv_q[62:0], 1'b0};
      if (dv_r7 >= {1'b0, div_dsor}) begin
        dv_r7   = dv_r7 - {1'b0, div_dsor};
        dv_q[0] = 1'b1;
      end
      dv_r = dv_r7[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_fin  <= 1'b0;
    end else begin
      div_fin <= 1'b0;
      if (div_start) begin
        div_busy <= 1'b1;
        div_cnt  <= '0;
        div_q    <= div_a;
        div_rem  <= '0;
        div_dsor <= div_d;
      end else if (div_busy) begin
        div_q   <= dv_q;
        div_rem <= dv_r;
        div_cnt <= div_cnt + 1'b1;
        if (div_cnt == 3'(64 / DIV_BITS - 1)) begin
          div_busy <= 1'b0;
          div_fin  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_a      = '0;
    div_d      = '0;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = B_FDIV;
        end
      end
      B_FDIV: begin
        if (step == 6'(FDIV_STEPS - 1)) begin
          mul_start  = 1'b1;
          mul_a      = {8'b0, fd_q_step};
          mul_b      = {8'b0, fd_q_step};
          state_next = B_ZSQ;
        end
      end
      B_ZSQ: begin
        if (mul_done) begin
          div_start  = 1'b1;
          div_a      = {8'b0, fd_q};
          div_d      = 6'd1;
          state_next = B_LN_DIV;
        end
      end
      B_LN_DIV: begin
        if (div_fin) begin
          mul_start  = 1'b1;
          mul_a      = t;
          mul_b      = w;
          state_next = B_LN_MUL;
        end
      end
      B_LN_MUL: begin
        if (mul_done) begin
          if (step == 6'(LN_TERMS - 1)) begin
            mul_start  = 1'b1;
            mul_a      = 64'(5'(LCG_W) - e);
            mul_b      = LN2_Q;
            state_next = B_LN_WHOLE;
          end else begin
            div_start  = 1'b1;
            div_a      = prod_mid;
            div_d      = {step[4:0], 1'b1} + 6'd2;
            state_next = B_LN_DIV;
          end
        end
      end
      B_LN_WHOLE: begin
        if (mul_done) state_next = B_SQRT;
      end
      B_SQRT: begin
        if (step == 6'(SQRT_STEPS - 1)) begin
          mul_start  = 1'b1;
          mul_a      = HALF_PI_Q;
          mul_b      = 64'(s2[THETA_SH-1:0]);
          state_next = B_THETA;
        end
      end
      B_THETA: begin
        if (mul_done) state_next = B_TRIG_ACC;
      end
      B_TRIG_ACC: begin
        if (step == 6'(TRIG_TERMS - 1)) begin
          state_next = B_QUAD;
        end else begin
          mul_start  = 1'b1;
          mul_a      = t;
          mul_b      = theta;
          state_next = B_TRIG_MUL;
        end
      end
      B_TRIG_MUL: begin
        if (mul_done) begin
          div_start  = 1'b1;
          div_a      = prod_mid;
          div_d      = {1'b0, step[4:0]} + 6'd1;
          state_next = B_TRIG_DIV;
        end
      end
      B_TRIG_DIV: begin
        if (div_fin) state_next = B_TRIG_ACC;
      end
      B_QUAD: begin
        mul_start  = 1'b1;
        mul_a      = r;
        mul_b      = abs64(cx_sel);
        state_next = B_X_AMP;
      end
      B_X_AMP: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = prod_mid;
          mul_b      = 64'(sd_x);
          state_next = B_X_SCALE;
        end
      end
      B_X_SCALE: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = r;
          mul_b      = abs64(sy);
          state_next = B_Y_AMP;
        end
      end
      B_Y_AMP: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = prod_mid;
          mul_b      = 64'(sd_y);
          state_next = B_Y_SCALE;
        end
      end
      B_Y_SCALE: begin
        if (mul_done) state_next = B_DONE;
      end
      B_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          s2   <= q_pair.s2;
          e    <= e_in;
          fd_r <= 33'(s1_fix - p_in);
          fd_d <= 33'(s1_fix) + 33'(p_in);
          fd_q <= '0;
          step <= '0;
        end
      end
      B_FDIV: begin
        fd_r <= fd_r_step;
        fd_q <= fd_q_step;
        step <= step + 1'b1;
      end
      B_ZSQ: begin
        if (mul_done) begin
          w    <= prod_mid;
          t    <= {8'b0, fd_q};
          sum  <= '0;
          step <= '0;
        end
      end
      B_LN_DIV: begin
        if (div_fin) sum <= sum + div_q;
      end
      B_LN_MUL: begin
        if (mul_done) begin
          t    <= prod_mid;
          step <= step + 1'b1;
        end
      end
      B_LN_WHOLE: begin
        if (mul_done) begin
          vrad   <= {neg_ln[62:0], 1'b0};
          root   <= '0;
          sq_bit <= SQRT_TOP;
          step   <= '0;
        end
      end
      B_SQRT: begin
        if (sq_ge) vrad <= vrad - sq_cand;
        root   <= root_step;
        sq_bit <= sq_bit >> 2;
        step   <= step + 1'b1;
        r      <= root_step << (FB / 2);
      end
      B_THETA: begin
        if (mul_done) begin
          theta <= mul_prod[THETA_SH +: 64];
          t     <= ONE_Q;
          c     <= '0;
          sn    <= '0;
          step  <= '0;
        end
      end
      B_TRIG_ACC: begin
        if (step[0]) sn <= sn + term;
        else         c  <= c + term;
      end
      B_TRIG_DIV: begin
        if (div_fin) begin
          t    <= div_q;
          step <= step + 1'b1;
        end
      end
      B_QUAD: begin
        cx <= cx_sel;
        sy <= sy_sel;
      end
      B_X_SCALE: begin
        if (mul_done) px <= saturate(scaled, cx[63]);
      end
      B_Y_SCALE: begin
        if (mul_done) py <= saturate(scaled, sy[63]);
      end
      default: ;
    endcase
  end

  // output register lets the next pair be worked on while this beat waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x <= px;
      out_y <= py;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.sample_x = out_x;
  assign rsp.sample_y = out_y;

endmodule

// ----- tb/gaussian_noise_pair_generator_test.sv -----
// Self-checking testbench for the gaussian noise pair generator
module gaussian_noise_pair_generator_test import gnpg_pkg::*; ();

  typedef struct {
    action_t          act;
    logic [LCG_W-1:0] seed;
  } request_t;

  typedef struct {
    logic [SAMPLE_W-1:0] x;
    logic [SAMPLE_W-1:0] y;
  } pair_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int OUT_FRAC_BITS  = 12;

  logic            clk;
  logic            rst;
  logic            cfg_we;
  logic            cfg_index;
  logic [SD_W-1:0] cfg_data;

  gnpg_req_if req ();
  gnpg_rsp_if rsp ();

  gaussian_noise_pair_generator #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  request_t         pending_reqs[$];
  pair_t            expected_pairs[$];
  logic [LCG_W-1:0] lcg;
  logic [SD_W-1:0]  sd_x, sd_y;
  bit               jitter;
  int               mismatches;
  int               src_gap, snk_gap;
  int               quiet_cycles;

  // ---------------- predictor ----------------
  function automatic logic [63:0] mul_sh(logic [63:0] a, logic [63:0] b, int sh, bit rnd);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (rnd) p = p + (128'd1 << (sh - 1));
    return p[sh +: 64];
  endfunction

  function automatic logic [63:0] fmul(logic [63:0] a, logic [63:0] b);
    return mul_sh(a, b, FB, 1'b0);
  endfunction

  function automatic logic [63:0] frac_div(logic [63:0] n, logic [63:0] d);
    logic [63:0] q, r;
    q = 0;
    r = n;
    for (int i = 0; i < FB; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = SQRT_TOP;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // -ln(s / 2^31), Q.FB
  function automatic logic [63:0] neg_log(logic [63:0] s);
    int          e;
    logic [63:0] p, z, w, t, sum, lnm, whole;
    e = 0;
    sum = 0;
    while (e < 30 && (s >> (e + 1)) != 0) e++;
    p = 64'd1 << e;
    z = frac_div(s - p, s + p);
    w = fmul(z, z);
    t = z;
    for (int k = 0; k < LN_TERMS; k++) begin
      sum = sum + t / (2 * k + 1);
      t = fmul(t, w);
    end
    lnm = 2 * sum;
    whole = 64'(31 - e) * LN2_Q;
    return (whole > lnm) ? whole - lnm : 64'd0;
  endfunction

  function automatic logic [SAMPLE_W-1:0] scale_sample(logic [63:0] r,
      logic signed [63:0] trig, logic [SD_W-1:0] sd);
    logic [63:0] mag, a, p;
    mag = (trig < 0) ? 64'd0 - trig : trig;
    a = fmul(r, mag);
    p = mul_sh(a, {48'd0, sd}, FB + SD_FRAC_BITS - OUT_FRAC_BITS, 1'b1);
    if (trig < 0) begin
      if (p > SAT_NEG) p = SAT_NEG;
      p = 64'd0 - p;
    end else if (p > SAT_POS) begin
      p = SAT_POS;
    end
    return p[SAMPLE_W-1:0];
  endfunction

  function automatic pair_t gaussian_pair();
    logic [63:0]        s1, s2, r, theta, t, frac;
    logic signed [63:0] c, sn, cx, sy, term;
    pair_t              res;
    lcg = lcg * LCG_MUL + LCG_INC;
    s1 = {33'd0, lcg};
    lcg = lcg * LCG_MUL + LCG_INC;
    s2 = {33'd0, lcg};
    if (s1 == 0) s1 = 1;   // zero uniform stands in as 2^-31
    r = root64(2 * neg_log(s1)) << (FB / 2);
    frac = s2 & 64'h1FFFFFFF;
    theta = mul_sh(HALF_PI_Q, frac, THETA_SH, 1'b0);
    c = 0;
    sn = 0;
    t = ONE_Q;
    for (int n = 0; n < TRIG_TERMS; n++) begin
      term = t;
      if (n[1]) term = -term;
      if (n[0]) sn = sn + term;
      else c = c + term;
      t = fmul(t, theta) / (n + 1);
    end
    case (s2[30:29])
      2'd0: begin cx = c; sy = sn; end
      2'd1: begin cx = -sn; sy = c; end
      2'd2: begin cx = -c; sy = -sn; end
      default: begin cx = sn; sy = -c; end
    endcase
    res.x = scale_sample(r, cx, sd_x);
    res.y = scale_sample(r, sy, sd_y);
    return res;
  endfunction

  // ---------------- clock and watchdog ----------------
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("gaussian_noise_pair_generator verification failed");
      $finish;
    end
  end

  // ---------------- request driver ----------------
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (req.valid && req.ready) begin
        if (req.action == ACT_LOAD) lcg = req.seed_value;
        else expected_pairs.push_back(gaussian_pair());
        void'(pending_reqs.pop_front());
      end
      if (!(req.valid && !req.ready)) begin
        if (src_gap > 0) begin
          src_gap--;
          req.valid <= 1'b0;
        end else if (jitter && $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(0, 4);
          req.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req.valid <= 1'b1;
          req.action <= pending_reqs[0].act;
          req.seed_value <= pending_reqs[0].seed;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- result monitor ----------------
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_pairs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected pair x=%0d y=%0d", rsp.sample_x, rsp.sample_y);
        end else begin
          if (rsp.sample_x !== expected_pairs[0].x || rsp.sample_y !== expected_pairs[0].y)
          begin
            mismatches++;
            if (mismatches <= 10)
              $display("pair mismatch: exp x=%0d y=%0d got x=%0d y=%0d",
                       $signed(expected_pairs[0].x), $signed(expected_pairs[0].y),
                       rsp.sample_x, rsp.sample_y);
          end
          void'(expected_pairs.pop_front());
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        rsp.ready <= 1'b0;
      end else if (jitter && $urandom_range(0, 5) == 0) begin
        snk_gap = $urandom_range(0, 4);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic push_req(action_t act, logic [LCG_W-1:0] seed);
    request_t it;
    it.act = act;
    it.seed = seed;
    pending_reqs.push_back(it);
  endtask

  task automatic set_std_devs(logic [SD_W-1:0] vx, logic [SD_W-1:0] vy);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_STD_DEV_X;
    cfg_data <= vx;
    @(posedge clk);
    cfg_index <= REG_STD_DEV_Y;
    cfg_data <= vy;
    @(posedge clk);
    cfg_we <= 1'b0;
    sd_x = vx;
    sd_y = vy;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_pairs.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_burst(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 6) == 0) push_req(ACT_LOAD, LCG_W'($urandom));
      else push_req(ACT_DRAW, LCG_W'($urandom));
    end
  endtask

  initial begin
    logic [LCG_W-1:0] inv, zero_seed;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_STD_DEV_X;
    cfg_data = '0;
    req.valid = 1'b0;
    req.action = ACT_DRAW;
    req.seed_value = '0;
    rsp.ready = 1'b0;
    lcg = '0;
    sd_x = SD_RESET;
    sd_y = SD_RESET;
    jitter = 1'b1;
    mismatches = 0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // seed whose successor is zero: s = -inc / mul mod 2^31 (Newton inverse)
    inv = LCG_MUL;
    repeat (5) inv = inv * (31'd2 - LCG_MUL * inv);
    zero_seed = (31'd0 - LCG_INC) * inv;

    // directed, reset scales
    push_req(ACT_DRAW, '1);
    push_req(ACT_DRAW, '0);
    push_req(ACT_LOAD, '0);
    push_req(ACT_DRAW, '1);
    push_req(ACT_LOAD, zero_seed);
    push_req(ACT_DRAW, '0);
    push_req(ACT_LOAD, 31'h7FFFFFFF);
    push_req(ACT_DRAW, '0);
    push_req(ACT_LOAD, 31'h55555555);
    push_req(ACT_LOAD, 31'h2AAAAAAA);
    push_req(ACT_DRAW, '0);
    for (int i = 0; i < 8; i++) push_req(ACT_DRAW, '1);
    drain();

    // scale extremes; drain between phases pauses the sender
    set_std_devs(16'd0, 16'hFFFF);
    push_req(ACT_LOAD, zero_seed);
    push_req(ACT_DRAW, '0);
    random_burst(150);
    drain();

    set_std_devs(16'hFFFF, 16'd0);
    push_req(ACT_LOAD, zero_seed);
    push_req(ACT_DRAW, '0);
    random_burst(150);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      set_std_devs(SD_W'($urandom), SD_W'($urandom));
      random_burst(150);
      drain();
    end

    // closing stretch at full rate
    jitter = 1'b0;
    set_std_devs(SD_RESET, 16'h0180);
    random_burst(120);
    drain();
    repeat (50) @(posedge clk);

    if (mismatches == 0 && expected_pairs.size() == 0) begin
      $display("gaussian_noise_pair_generator verification clean");
    end else begin
      $display("gaussian_noise_pair_generator verification failed");
    end
    $finish;
  end

endmodule
